### hdl/svpg_pkg.sv
// ----------------------------------------------------------------------------
// svpg_pkg
// Shared codes and types of the multichannel servo pulse generator.
// ----------------------------------------------------------------------------
package svpg_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int TICK_W   = 16;
  localparam int SAMPLE_W = 10;
  localparam int PINS_W   = 8;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ATTACH = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADC    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ANGLE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICKS  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_UNUSED   = 2'd3;

  localparam logic CFG_PERIOD  = 1'b0;
  localparam logic CFG_DEFAULT = 1'b1;

  localparam logic [TICK_W-1:0] PERIOD_RESET  = 16'd1000;
  localparam logic [TICK_W-1:0] DEFAULT_RESET = 16'd75;
  localparam logic [TICK_W-1:0] ANGLE_SPAN    = 16'd180;

  // 180 = 4 * 45: x / 180 = ((x >> 2) * ANGLE_RECIP) >> ANGLE_RECIP_SH,
  // exact for any 32-bit x
  localparam logic [30:0] ANGLE_RECIP    = 31'd1527099484;
  localparam int          ANGLE_RECIP_SH = 36;

  // calibration limits of one channel, one word of the limits memory
  typedef struct packed {
    logic [TICK_W-1:0]   tick_floor;
    logic [TICK_W-1:0]   tick_ceiling;
    logic [SAMPLE_W-1:0] sample_floor;
    logic [SAMPLE_W-1:0] sample_ceiling;
  } svpg_limits_t;

endpackage

### hdl/svpg_ram.sv
// ----------------------------------------------------------------------------
// svpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/multichannel_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// multichannel_servo_pulse_generator
// Servo pulse generator: shared frame counter, per-channel pulse widths and
// calibration limits kept in two small RAMs.
// ----------------------------------------------------------------------------
// To the strobe: attach, ignored, rejected direct; set ticks, zero-span ADC RD,
// CALC; angle also MUL, RECIP (reciprocal multiply), WB; from ADC also MUL, DIV
// (32-step divider), WB; tick TK_RD (pulse RAM read), TK_UP per channel. One
// request at a time: busy stays high through the strobe, next accept after it.
// Synchronous active-low reset: all channels detached, pins low, counter 0,
// pulse widths read as the default through per-channel valid bits.
module multichannel_servo_pulse_generator
  import svpg_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [7:0]          in_channel,
  input  logic [TICK_W-1:0]   in_setting_value,
  input  logic [TICK_W-1:0]   in_low_tick,
  input  logic [TICK_W-1:0]   in_high_tick,
  input  logic [SAMPLE_W-1:0] in_low_sample,
  input  logic [SAMPLE_W-1:0] in_high_sample,
  output logic                out_valid,
  output logic [PINS_W-1:0]   out_pin_levels,
  output logic [STATUS_W-1:0] out_status,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [TICK_W-1:0]   cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TK_RD = 4'd1;
  localparam logic [3:0] ST_TK_UP = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_CALC  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_WB    = 4'd7;
  localparam logic [3:0] ST_RESP  = 4'd8;
  localparam logic [3:0] ST_RECIP = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [CH_W-1:0]     chan_r, chan_nxt;
  logic [TICK_W-1:0]   val_r, val_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CH_W-1:0]     idx_r, idx_nxt;
  logic [TICK_W-1:0]   frame_r, frame_nxt;
  logic [TICK_W-1:0]   period_r, period_nxt;
  logic [TICK_W-1:0]   dflt_r, dflt_nxt;
  logic [CHANNELS-1:0] en_r, en_nxt;
  logic [CHANNELS-1:0] pvld_r, pvld_nxt;
  logic [CHANNELS-1:0] level_r, level_nxt;
  logic [TICK_W-1:0]   a_r, a_nxt;
  logic [TICK_W-1:0]   b_r, b_nxt;
  logic [TICK_W-1:0]   den_r, den_nxt;
  logic [TICK_W-1:0]   tf_r, tf_nxt;
  logic [31:0]         num_r, num_nxt;
  logic [TICK_W-1:0]   rem_r, rem_nxt;
  logic [4:0]          cnt_r, cnt_nxt;

  logic                lim_we;
  svpg_limits_t        lim_wdata, lim_rdata;
  logic                pul_we;
  logic [TICK_W-1:0]   pul_wdata, pul_rdata;

  logic                accept;
  logic                ch_ok;
  logic [CH_W-1:0]     ch_idx;
  logic [TICK_W-1:0]   pulse_cur;
  logic [TICK_W-1:0]   clamp_t;
  logic [TICK_W-1:0]   clamp_s;
  logic [SAMPLE_W-1:0] span;
  logic [TICK_W:0]     rem_sh;
  logic [TICK_W:0]     frame_inc;
  logic [60:0]         recip_prod;

  assign accept    = start && !busy;
  assign ch_ok     = {1'b0, in_channel} < 9'(CHANNELS);
  assign ch_idx    = in_channel[CH_W-1:0];
  assign busy      = state_r != ST_IDLE;
  assign out_valid = state_r == ST_RESP;
  assign out_status = status_r;

  for (genvar i = 0; i < PINS_W; i++) begin : g_pins
    if (i < CHANNELS) begin : g_on
      assign out_pin_levels[i] = level_r[i];
    end else begin : g_off
      assign out_pin_levels[i] = 1'b0;
    end
  end

  assign lim_wdata = '{tick_floor: in_low_tick, tick_ceiling: in_high_tick,
                       sample_floor: in_low_sample, sample_ceiling: in_high_sample};

  svpg_ram #(.WIDTH($bits(svpg_limits_t)), .DEPTH(CHANNELS)) u_lim_ram (
    .clk   (clk),
    .we    (lim_we),
    .waddr (ch_idx),
    .wdata (lim_wdata),
    .raddr (chan_r),
    .rdata (lim_rdata)
  );

  svpg_ram #(.WIDTH(TICK_W), .DEPTH(CHANNELS)) u_pulse_ram (
    .clk   (clk),
    .we    (pul_we),
    .waddr (chan_r),
    .wdata (pul_wdata),
    .raddr (idx_r),
    .rdata (pul_rdata)
  );

  // unwritten pulse entries read as the default width
  assign pulse_cur  = pvld_r[idx_r] ? pul_rdata : dflt_r;
  assign frame_inc  = {1'b0, frame_r} + 17'd1;
  assign rem_sh     = {rem_r, num_r[31]};
  assign span       = lim_rdata.sample_ceiling - lim_rdata.sample_floor;
  assign recip_prod = {31'd0, num_r[31:2]} * {30'd0, ANGLE_RECIP};

  always_comb begin
    clamp_t = val_r;
    if (clamp_t < lim_rdata.tick_floor) clamp_t = lim_rdata.tick_floor;
    if (clamp_t > lim_rdata.tick_ceiling) clamp_t = lim_rdata.tick_ceiling;
    clamp_s = val_r;
    if (clamp_s < {6'd0, lim_rdata.sample_floor}) clamp_s = {6'd0, lim_rdata.sample_floor};
    if (clamp_s > {6'd0, lim_rdata.sample_ceiling}) clamp_s = {6'd0, lim_rdata.sample_ceiling};
  end

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    chan_nxt   = chan_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    frame_nxt  = frame_r;
    period_nxt = period_r;
    dflt_nxt   = dflt_r;
    en_nxt     = en_r;
    pvld_nxt   = pvld_r;
    level_nxt  = level_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    den_nxt    = den_r;
    tf_nxt     = tf_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    lim_we     = 1'b0;
    pul_we     = 1'b0;
    pul_wdata  = clamp_t;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD:  period_nxt = cfg_data;
        CFG_DEFAULT: begin
          dflt_nxt = cfg_data;
          pvld_nxt = '0;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt   = in_func;
          chan_nxt   = ch_idx;
          val_nxt    = in_setting_value;
          status_nxt = STAT_DONE;
          idx_nxt    = '0;
          state_nxt  = ST_RESP;
          if (in_func == FUNC_TICK) begin
            state_nxt = ST_TK_RD;
          end else if (in_func > FUNC_TICKS || !ch_ok) begin
            status_nxt = STAT_IGNORED;
          end else if (in_func == FUNC_ATTACH) begin
            if (in_low_tick > in_high_tick || in_low_sample > in_high_sample) begin
              status_nxt = STAT_REJECTED;
            end else begin
              lim_we         = 1'b1;
              en_nxt[ch_idx] = 1'b1;
            end
          end else if (!en_r[ch_idx]) begin
            status_nxt = STAT_IGNORED;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_TK_RD: state_nxt = ST_TK_UP;
      ST_TK_UP: begin
        if (en_r[idx_r]) begin
          if (frame_r == '0) begin
            level_nxt[idx_r] = 1'b1;
          end else if (frame_r == pulse_cur) begin
            level_nxt[idx_r] = 1'b0;
          end
        end
        if (idx_r == LAST_CH) begin
          frame_nxt = (frame_inc >= {1'b0, period_r}) ? '0 : frame_inc[TICK_W-1:0];
          state_nxt = ST_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_TK_RD;
        end
      end
      ST_RD: state_nxt = ST_CALC;
      ST_CALC: begin
        tf_nxt = lim_rdata.tick_floor;
        b_nxt  = lim_rdata.tick_ceiling - lim_rdata.tick_floor;
        priority case (func_r)
          FUNC_TICKS: begin
            pul_we             = 1'b1;
            pvld_nxt[chan_r]   = 1'b1;
            state_nxt          = ST_RESP;
          end
          FUNC_ANGLE: begin
            a_nxt     = val_r;
            state_nxt = ST_MUL;
          end
          default: begin
            if (span == '0) begin
              // zero ADC span: take the tick floor
              pul_wdata        = lim_rdata.tick_floor;
              pul_we           = 1'b1;
              pvld_nxt[chan_r] = 1'b1;
              state_nxt        = ST_RESP;
            end else begin
              a_nxt     = clamp_s - {6'd0, lim_rdata.sample_floor};
              den_nxt   = {6'd0, span};
              state_nxt = ST_MUL;
            end
          end
        endcase
      end
      ST_MUL: begin
        num_nxt   = a_r * b_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = (func_r == FUNC_ANGLE) ? ST_RECIP : ST_DIV;
      end
      ST_RECIP: begin
        // divide by the angle span through its reciprocal
        num_nxt   = {16'd0, recip_prod[ANGLE_RECIP_SH +: TICK_W]};
        state_nxt = ST_WB;
      end
      ST_DIV: begin
        // one restoring step per cycle, quotient shifts into num_r
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = TICK_W'(rem_sh - {1'b0, den_r});
          num_nxt = {num_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[TICK_W-1:0];
          num_nxt = {num_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_WB;
      end
      ST_WB: begin
        pul_wdata        = tf_r + num_r[TICK_W-1:0];
        pul_we           = 1'b1;
        pvld_nxt[chan_r] = 1'b1;
        state_nxt        = ST_RESP;
      end
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      status_r <= STAT_DONE;
      idx_r    <= '0;
      frame_r  <= '0;
      period_r <= PERIOD_RESET;
      dflt_r   <= DEFAULT_RESET;
      en_r     <= '0;
      pvld_r   <= '0;
      level_r  <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      frame_r  <= frame_nxt;
      period_r <= period_nxt;
      dflt_r   <= dflt_nxt;
      en_r     <= en_nxt;
      pvld_r   <= pvld_nxt;
      level_r  <= level_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    chan_r <= chan_nxt;
    val_r  <= val_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    den_r  <= den_nxt;
    tf_r   <= tf_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

### hdl/svpg_checker.sv
// ----------------------------------------------------------------------------
// svpg_checker
// Port-level checks of the servo pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module svpg_checker
  import svpg_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status
);

  // an accepted request occupies the block until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // the result strobe ends the request: never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != STAT_UNUSED)
    else $error("result carries an unused status code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind multichannel_servo_pulse_generator svpg_checker u_svpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status)
);
